### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Each macro expects clk and rst_n in the scope where it is used.

`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Same-cycle implication check failed.");

`define ASSERT_IMPLIES_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Next-cycle implication check failed.");

`endif

### rtl/tarv_pkg.sv
`timescale 1ns / 1ps

package tarv_pkg;

  localparam int unsigned REG_COUNT_DEFAULT = 128;
  localparam int unsigned CMD_W             = 4;
  localparam int unsigned INDEX_W           = 7;
  localparam int unsigned DATA_W            = 32;
  localparam int unsigned DIV_STEP_W        = $clog2(DATA_W);

  typedef enum logic [CMD_W-1:0] {
    OP_SET = 4'd0,
    OP_ADD = 4'd1,
    OP_SUB = 4'd2,
    OP_MUL = 4'd3,
    OP_DIV = 4'd4,
    OP_LT  = 4'd5,
    OP_LE  = 4'd6,
    OP_GT  = 4'd7,
    OP_GE  = 4'd8,
    OP_RET = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_DIVFIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic read;
    logic exec;
    logic div_step;
    logic div_fin;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_div;
    logic div_last;
  } ctl_sts_t;

endpackage

### rtl/tarv_if.sv
`timescale 1ns / 1ps

interface tarv_in_if;
  logic                                valid;
  logic                                ready;
  logic [tarv_pkg::CMD_W-1:0]          cmd;
  logic [tarv_pkg::INDEX_W-1:0]        dest_index;
  logic [tarv_pkg::INDEX_W-1:0]        src_a_index;
  logic [tarv_pkg::INDEX_W-1:0]        src_b_index;
  logic signed [tarv_pkg::DATA_W-1:0]  immediate;

  modport source (output valid, cmd, dest_index, src_a_index, src_b_index, immediate,
                  input ready);
  modport sink (input valid, cmd, dest_index, src_a_index, src_b_index, immediate,
                output ready);
endinterface

interface tarv_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tarv_pkg::DATA_W-1:0]  value;
  logic                                is_return;
  logic                                wrote_reg;

  modport source (output valid, value, is_return, wrote_reg, input ready);
  modport sink (input valid, value, is_return, wrote_reg, output ready);
endinterface

### rtl/tarv_dpath.sv
`timescale 1ns / 1ps

module tarv_dpath #(
  parameter int unsigned REG_COUNT = tarv_pkg::REG_COUNT_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tarv_pkg::ctl_cmd_t                 cmd,
  output tarv_pkg::ctl_sts_t                 sts,
  input  logic [tarv_pkg::CMD_W-1:0]         in_cmd,
  input  logic [tarv_pkg::INDEX_W-1:0]       in_dest_index,
  input  logic [tarv_pkg::INDEX_W-1:0]       in_src_a_index,
  input  logic [tarv_pkg::INDEX_W-1:0]       in_src_b_index,
  input  logic signed [tarv_pkg::DATA_W-1:0] in_immediate,
  output logic signed [tarv_pkg::DATA_W-1:0] out_value,
  output logic                               out_is_return,
  output logic                               out_wrote_reg
);

  localparam int unsigned DATA_W = tarv_pkg::DATA_W;
  localparam int unsigned STEP_W = tarv_pkg::DIV_STEP_W;
  localparam int unsigned IDX_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int unsigned SRC_N  = 2 ** tarv_pkg::INDEX_W;

  // Maps every encodable register index onto the file, wrapping at REG_COUNT.
  function automatic logic [SRC_N-1:0][IDX_W-1:0] build_slot_lut();
    logic [SRC_N-1:0][IDX_W-1:0] lut;
    int unsigned                 c;
    c = 0;
    for (int unsigned i = 0; i < SRC_N; i++) begin
      lut[i] = IDX_W'(c);
      if (c == REG_COUNT - 1) begin
        c = 0;
      end else begin
        c = c + 1;
      end
    end
    return lut;
  endfunction

  localparam logic [SRC_N-1:0][IDX_W-1:0] SLOT_LUT = build_slot_lut();

  logic [DATA_W-1:0]        mem [REG_COUNT];

  tarv_pkg::op_t            op_r;
  logic [IDX_W-1:0]         dest_r;
  logic [IDX_W-1:0]         src_a_r;
  logic [IDX_W-1:0]         src_b_r;
  logic [DATA_W-1:0]        imm_r;
  logic [DATA_W-1:0]        rd_a_r;
  logic [DATA_W-1:0]        rd_b_r;
  logic [DATA_W-1:0]        res_r;
  logic                     ret_r;
  logic                     wrote_r;
  logic [IDX_W-1:0]         clr_idx_r;
  logic [DATA_W-1:0]        rem_r;
  logic [DATA_W-1:0]        quo_r;
  logic [DATA_W-1:0]        dvs_r;
  logic                     neg_r;
  logic                     bz_r;
  logic [STEP_W-1:0]        cnt_r;
  logic [DATA_W-1:0]        out_value_r;
  logic                     out_ret_r;
  logic                     out_wrote_r;

  logic [IDX_W-1:0]         rd_addr_a;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_wa;
  logic [DATA_W-1:0]        mem_wd;
  logic [DATA_W-1:0]        alu_res;
  logic                     alu_ret;
  logic                     alu_wrote;
  logic [DATA_W-1:0]        a_mag;
  logic [DATA_W-1:0]        b_mag;
  logic [DATA_W:0]          div_tmp;
  logic [DATA_W:0]          div_diff;

  assign rd_addr_a = (op_r == tarv_pkg::OP_RET) ? dest_r : src_a_r;
  assign mem_we    = cmd.clear || (cmd.commit && wrote_r);
  assign mem_wa    = cmd.clear ? clr_idx_r : dest_r;
  assign mem_wd    = cmd.clear ? '0 : res_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.read) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[src_b_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clear) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= tarv_pkg::op_t'(in_cmd);
      dest_r  <= SLOT_LUT[in_dest_index];
      src_a_r <= SLOT_LUT[in_src_a_index];
      src_b_r <= SLOT_LUT[in_src_b_index];
      imm_r   <= in_immediate;
    end
  end

  always_comb begin
    alu_res   = '0;
    alu_ret   = 1'b0;
    alu_wrote = 1'b1;
    unique case (op_r) inside
      tarv_pkg::OP_SET: alu_res = imm_r;
      tarv_pkg::OP_ADD: alu_res = rd_a_r + rd_b_r;
      tarv_pkg::OP_SUB: alu_res = rd_a_r - rd_b_r;
      tarv_pkg::OP_MUL: alu_res = rd_a_r * rd_b_r;
      tarv_pkg::OP_DIV: alu_res = '0;
      tarv_pkg::OP_LT:  alu_res = DATA_W'($signed(rd_a_r) <  $signed(rd_b_r));
      tarv_pkg::OP_LE:  alu_res = DATA_W'($signed(rd_a_r) <= $signed(rd_b_r));
      tarv_pkg::OP_GT:  alu_res = DATA_W'($signed(rd_a_r) >  $signed(rd_b_r));
      tarv_pkg::OP_GE:  alu_res = DATA_W'($signed(rd_a_r) >= $signed(rd_b_r));
      tarv_pkg::OP_RET: begin
        alu_res   = rd_a_r;
        alu_ret   = 1'b1;
        alu_wrote = 1'b0;
      end
      default: alu_wrote = 1'b0;
    endcase
  end

  assign a_mag    = rd_a_r[DATA_W-1] ? DATA_W'(-rd_a_r) : rd_a_r;
  assign b_mag    = rd_b_r[DATA_W-1] ? DATA_W'(-rd_b_r) : rd_b_r;
  assign div_tmp  = {rem_r, quo_r[DATA_W-1]};
  assign div_diff = div_tmp - {1'b0, dvs_r};

  // Registers the ALU result; restoring divider on magnitudes, one quotient bit per step.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r   <= alu_res;
      ret_r   <= alu_ret;
      wrote_r <= alu_wrote;
      rem_r   <= '0;
      quo_r   <= a_mag;
      dvs_r   <= b_mag;
      neg_r   <= rd_a_r[DATA_W-1] ^ rd_b_r[DATA_W-1];
      bz_r    <= (rd_b_r == '0);
      cnt_r   <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (!div_diff[DATA_W]) begin
        rem_r <= div_diff[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= div_tmp[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end else if (cmd.div_fin) begin
      if (bz_r) begin
        res_r <= '1;
      end else if (neg_r) begin
        res_r <= DATA_W'(-quo_r);
      end else begin
        res_r <= quo_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_value_r <= res_r;
      out_ret_r   <= ret_r;
      out_wrote_r <= wrote_r;
    end
  end

  assign sts.clr_last = (clr_idx_r == IDX_W'(REG_COUNT - 1));
  assign sts.is_div   = (op_r == tarv_pkg::OP_DIV);
  assign sts.div_last = (cnt_r == STEP_W'(DATA_W - 1));

  assign out_value     = out_value_r;
  assign out_is_return = out_ret_r;
  assign out_wrote_reg = out_wrote_r;

endmodule

### rtl/tarv_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tarv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output tarv_pkg::ctl_cmd_t cmd,
  input  tarv_pkg::ctl_sts_t sts
);

  tarv_pkg::state_t state_r;
  tarv_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             slot_free;
  logic             div_done;

  assign slot_free = !out_valid_r || out_ready;
  assign div_done  = (state_r == tarv_pkg::S_DIV) && sts.div_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tarv_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tarv_pkg::S_CLEAR:  if (sts.clr_last) state_nxt = tarv_pkg::S_IDLE;
      tarv_pkg::S_IDLE:   if (in_valid) state_nxt = tarv_pkg::S_READ;
      tarv_pkg::S_READ:   state_nxt = tarv_pkg::S_EXEC;
      tarv_pkg::S_EXEC:   state_nxt = sts.is_div ? tarv_pkg::S_DIV : tarv_pkg::S_DONE;
      tarv_pkg::S_DIV:    if (sts.div_last) state_nxt = tarv_pkg::S_DIVFIN;
      tarv_pkg::S_DIVFIN: state_nxt = tarv_pkg::S_DONE;
      tarv_pkg::S_DONE:   if (slot_free) state_nxt = tarv_pkg::S_IDLE;
      default:            state_nxt = tarv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      tarv_pkg::S_CLEAR:  cmd.clear = 1'b1;
      tarv_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      tarv_pkg::S_READ:   cmd.read = 1'b1;
      tarv_pkg::S_EXEC:   cmd.exec = 1'b1;
      tarv_pkg::S_DIV:    cmd.div_step = 1'b1;
      tarv_pkg::S_DIVFIN: cmd.div_fin = 1'b1;
      tarv_pkg::S_DONE:   cmd.commit = slot_free;
      default:            cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_IMPLIES(a_commit_slot_free, cmd.commit, !out_valid_r || out_ready)
  `ASSERT_IMPLIES_NEXT(a_transfer_reads, in_valid && in_ready, state_r == tarv_pkg::S_READ)
  `ASSERT_IMPLIES_NEXT(a_div_ends, div_done, state_r == tarv_pkg::S_DIVFIN)

endmodule

### rtl/three_address_register_vm_exec.sv
`timescale 1ns / 1ps
// An instruction passes S_READ, S_EXEC, S_DIV and S_DIVFIN (divides only) and S_DONE,
// committing to the output registers once the output slot is free; in_ch.ready is high
// only in S_IDLE, so one instruction is handled at a time. Divides use a 32-step radix-2
// divider; the register file has one write and two read ports. Reset: synchronous, active
// low; afterwards a clearing pass zeroes the register file while in_ch.ready stays low.

module three_address_register_vm_exec #(
  parameter int unsigned REG_COUNT = tarv_pkg::REG_COUNT_DEFAULT
) (
  input logic          clk,
  input logic          rst_n,
  tarv_in_if.sink      in_ch,
  tarv_out_if.source   out_ch
);

  tarv_pkg::ctl_cmd_t cmd;
  tarv_pkg::ctl_sts_t sts;

  tarv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tarv_dpath #(
    .REG_COUNT (REG_COUNT)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_cmd         (in_ch.cmd),
    .in_dest_index  (in_ch.dest_index),
    .in_src_a_index (in_ch.src_a_index),
    .in_src_b_index (in_ch.src_b_index),
    .in_immediate   (in_ch.immediate),
    .out_value      (out_ch.value),
    .out_is_return  (out_ch.is_return),
    .out_wrote_reg  (out_ch.wrote_reg)
  );

endmodule
